/* rtl/lru_page_replacement_core_defines.svh */
// Assertion macros shared by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define LRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru assertion failed");

`else

`define LRU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/lru_pkg.sv */
// Package with shared constants for the LRU page replacement core.
`default_nettype none

package lru_pkg;

  // Default sizing
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed port widths
  localparam int PAGE_PORT_W  = 16;
  localparam int FRAME_IDX_W  = 3;
  localparam int CFG_W        = 4;
  localparam int FAULT_W      = 32;

  // Reset value of the frames-in-use register
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

endpackage

`default_nettype wire

/* rtl/lru_select.sv */
// Parallel tag match and LRU victim selection over the valid, active frames.
`default_nettype none

module lru_select #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
  parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int RANK_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  wire logic [FRAMES-1:0]                frame_valid,
  input  wire logic [FRAMES-1:0]                frame_active,
  input  wire logic [FRAMES-1:0][PAGE_BITS-1:0] frame_page,
  input  wire logic [FRAMES-1:0][RANK_W-1:0]    frame_rank,
  input  wire logic [PAGE_BITS-1:0]             page,
  output logic                                  hit,
  output logic [IDX_W-1:0]                      hit_idx,
  output logic                                  victim_any,
  output logic [IDX_W-1:0]                      victim_idx
);

  import lru_pkg::*;

  logic [FRAMES-1:0] live;
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] oldest;

  // Per-frame tag compare and pairwise rank compare
  always_comb begin
    live  = frame_valid & frame_active;
    match = '0;
    oldest = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = live[i] && (frame_page[i] == page);
      oldest[i] = live[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (live[j] && (j != i)) begin
          // earlier frames must be strictly younger, later ones no older
          if (j < i) begin
            if (!(frame_rank[j] < frame_rank[i])) oldest[i] = 1'b0;
          end else begin
            if (frame_rank[j] > frame_rank[i]) oldest[i] = 1'b0;
          end
        end
      end
    end
  end

  // Lowest-index priority encoders
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i])  hit_idx    = IDX_W'(i);
      if (oldest[i]) victim_idx = IDX_W'(i);
    end
  end

  assign hit        = |match;
  assign victim_any = |oldest;

endmodule

`default_nettype wire

/* rtl/lru_page_replacement_core.sv */
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while out_ready is high; tag match, victim pick and
// rank update share one combinational pass between the input and result registers.
// Reset (rst_n low, synchronous): all frames invalid, ranks, fill count and fault
// total cleared, frames_in_use set to 8; frame contents are not cleared.
`default_nettype none
`include "lru_page_replacement_core_defines.svh"

module lru_page_replacement_core #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [lru_pkg::CFG_W-1:0]         cfg_wr_data,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [lru_pkg::PAGE_PORT_W-1:0]   in_page_number,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic [lru_pkg::FRAME_IDX_W-1:0]        out_frame_index,
  output logic                                   out_evicted_valid,
  output logic [lru_pkg::PAGE_PORT_W-1:0]        out_evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]            out_fault_total
);

  import lru_pkg::*;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FILL_W = $clog2(FRAMES + 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FRAMES);

  // Configuration and control state
  logic [CFG_W-1:0]                frames_in_use_r;
  logic                            in_valid_r;
  logic [PAGE_BITS-1:0]            in_page_r;
  logic [FRAMES-1:0][PAGE_BITS-1:0] frame_page_r;
  logic [FRAMES-1:0]               frame_valid_r, frame_valid_nxt;
  logic [FRAMES-1:0][RANK_W-1:0]   rank_r, rank_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic [FAULT_W-1:0]              fault_r, fault_nxt;

  // Result register
  logic                            out_valid_r;
  logic                            out_hit_r;
  logic [FRAME_IDX_W-1:0]          out_frame_index_r;
  logic                            out_evicted_valid_r;
  logic [PAGE_PORT_W-1:0]          out_evicted_page_r;
  logic [FAULT_W-1:0]              out_fault_total_r;

  logic                            advance;
  logic [FRAMES-1:0]               active;
  logic [FILL_W-1:0]               n_active;
  logic                            full;
  logic                            hit;
  logic [IDX_W-1:0]                hit_idx;
  logic                            victim_any;
  logic [IDX_W-1:0]                victim_idx;
  logic [IDX_W-1:0]                f_idx;
  logic                            ev_valid;
  logic [PAGE_PORT_W-1:0]          ev_page;

  // Handshake: item moves to the result register when it is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Active frame window; zero acts as one, oversize acts as FRAMES
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (frames_in_use_r == '0) active[i] = (i == 0);
      else                       active[i] = (32'(frames_in_use_r) > i);
    end
    if (frames_in_use_r == '0)                n_active = FILL_W'(1);
    else if (32'(frames_in_use_r) > FRAMES)   n_active = FILL_MAX;
    else                                      n_active = FILL_W'(frames_in_use_r);
  end

  assign full = !(fill_r < n_active);

  lru_select #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W),
    .RANK_W    (RANK_W)
  ) u_select (
    .frame_valid  (frame_valid_r),
    .frame_active (active),
    .frame_page   (frame_page_r),
    .frame_rank   (rank_r),
    .page         (in_page_r),
    .hit          (hit),
    .hit_idx      (hit_idx),
    .victim_any   (victim_any),
    .victim_idx   (victim_idx)
  );

  // Frame choice and eviction
  always_comb begin
    if (hit)        f_idx = hit_idx;
    else if (!full) f_idx = fill_r[IDX_W-1:0];
    else            f_idx = victim_idx;
    ev_valid = !hit && full && victim_any;
    ev_page  = ev_valid ? PAGE_PORT_W'(frame_page_r[victim_idx]) : '0;
  end

  // Recency ageing, fill and fault counters
  always_comb begin
    frame_valid_nxt = frame_valid_r;
    rank_nxt        = rank_r;
    fill_nxt        = fill_r;
    fault_nxt       = fault_r;
    for (int i = 0; i < FRAMES; i++) begin
      if ((IDX_W'(i) != f_idx) && frame_valid_r[i] && active[i] &&
          (!hit || (rank_r[i] < rank_r[f_idx])) && (rank_r[i] < RANK_MAX)) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
    end
    rank_nxt[f_idx] = '0;
    if (!hit) begin
      frame_valid_nxt[f_idx] = 1'b1;
      if (!full) fill_nxt = fill_r + FILL_W'(1);
      if (fault_r != '1) fault_nxt = fault_r + FAULT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FRAMES_IN_USE_RST;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      frame_valid_r   <= '0;
      rank_r          <= '0;
      fill_r          <= '0;
      fault_r         <= '0;
    end else begin
      if (cfg_wr_en) frames_in_use_r <= cfg_wr_data;
      if (in_ready) in_valid_r <= in_valid;
      if (advance) begin
        out_valid_r   <= 1'b1;
        frame_valid_r <= frame_valid_nxt;
        rank_r        <= rank_nxt;
        fill_r        <= fill_nxt;
        fault_r       <= fault_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_page_r <= PAGE_BITS'(in_page_number);
    if (advance) begin
      if (!hit) frame_page_r[f_idx] <= in_page_r;
      out_hit_r           <= hit;
      out_frame_index_r   <= FRAME_IDX_W'(f_idx);
      out_evicted_valid_r <= ev_valid;
      out_evicted_page_r  <= ev_page;
      out_fault_total_r   <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_total   = out_fault_total_r;

  // Checks
  `LRU_ASSERT_IMPL(a_hit_no_evict, clk, rst_n, out_valid_r && out_hit_r,
                   !out_evicted_valid_r && (out_evicted_page_r == '0))
  `LRU_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_MAX)
  `LRU_ASSERT_NEXT(a_fault_step, clk, rst_n, advance && !hit,
                   (fault_r == $past(fault_r) + FAULT_W'(1)) || ($past(fault_r) == '1))
  `LRU_ASSERT_NEXT(a_hit_keeps_fault, clk, rst_n, advance && hit,
                   (fault_r == $past(fault_r)) && (fill_r == $past(fill_r)))
  `LRU_ASSERT_IMPL(a_evict_when_full, clk, rst_n, advance && ev_valid, full && !hit)

endmodule

`default_nettype wire
